@@ hdl/clp_pkg.sv @@
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types and constants of the chunk-size line parser: byte codes,
// the classified word passed from front to back and the result word.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int SIZE_BITS_DEF   = 31;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_SIZE_W      = 31;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // classified input word
  typedef struct packed {
    logic       is_end;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_ws;
    logic       is_semi;
    logic       is_eq;
    logic       is_quote;
    logic       is_bslash;
    logic       is_tchar;
    logic       is_ctl;
  } cls_t;

  typedef struct packed {
    logic [OUT_SIZE_W-1:0] chunk_size;
    logic                  malformed;
  } res_t;

endpackage

@@ hdl/clp_front.sv @@
// ----------------------------------------------------------------------------
// clp_front
// Front end: classifies each incoming word into the byte classes that the
// line grammar needs, so the back end only sees flags and a hex digit.
// ----------------------------------------------------------------------------
module clp_front (
  input  logic          [7:0] in_line_byte,
  input  logic                in_line_end,
  output clp_pkg::cls_t       cls
);
  import clp_pkg::*;

  logic [7:0] b;
  logic       hex_dec;
  logic       hex_lo;
  logic       hex_up;
  logic       delim;

  assign b = in_line_byte;

  assign hex_dec = (b >= 8'h30) && (b <= 8'h39);
  assign hex_lo  = (b >= 8'h61) && (b <= 8'h66);
  assign hex_up  = (b >= 8'h41) && (b <= 8'h46);

  always_comb begin
    case (b) inside
      8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D: delim = 1'b1;
      default: delim = 1'b0;
    endcase
  end

  always_comb begin
    cls.is_end    = in_line_end;
    cls.is_hex    = hex_dec || hex_lo || hex_up;
    if (hex_dec) begin
      cls.hex_val = b[3:0];
    end else begin
      // 'a'..'f' and 'A'..'F' share the low nibble 1..6
      cls.hex_val = b[3:0] + 4'd9;
    end
    cls.is_ws     = (b == CH_TAB) || (b == CH_SPACE);
    cls.is_semi   = (b == CH_SEMI);
    cls.is_eq     = (b == CH_EQ);
    cls.is_quote  = (b == CH_QUOTE);
    cls.is_bslash = (b == CH_BSLASH);
    cls.is_tchar  = (b >= 8'h21) && (b <= 8'h7E) && !delim;
    cls.is_ctl    = ((b < 8'h20) && (b != CH_TAB)) || (b == CH_DEL);
  end

endmodule

@@ hdl/clp_fifo.sv @@
// ----------------------------------------------------------------------------
// clp_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module clp_fifo #(
  parameter int DEPTH = clp_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import clp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ hdl/clp_back.sv @@
// ----------------------------------------------------------------------------
// clp_back
// Back end: walks the chunk-size line grammar one queued word per cycle (an end word
// waits while the result queue is full), accumulates the hex size, emits a result per end word.
// ----------------------------------------------------------------------------
module clp_back #(
  parameter int SIZE_BITS = clp_pkg::SIZE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  clp_pkg::cls_t item,
  input  logic          item_empty,
  output logic          item_pop,
  input  logic          res_full,
  output logic          res_push,
  output clp_pkg::res_t res
);
  import clp_pkg::*;

  localparam int WIDE_W = (SIZE_BITS > OUT_SIZE_W) ? SIZE_BITS : OUT_SIZE_W;

  typedef enum logic [12:0] {
    PH_FIRST   = 13'b0000000000001,
    PH_SIZE    = 13'b0000000000010,
    PH_SIZE_WS = 13'b0000000000100,
    PH_SEMI_WS = 13'b0000000001000,
    PH_NAME    = 13'b0000000010000,
    PH_NAME_WS = 13'b0000000100000,
    PH_EQ_WS   = 13'b0000001000000,
    PH_TOKVAL  = 13'b0000010000000,
    PH_QSTR    = 13'b0000100000000,
    PH_QESC    = 13'b0001000000000,
    PH_AFTERQ  = 13'b0010000000000,
    PH_VAL_WS  = 13'b0100000000000,
    PH_ERR     = 13'b1000000000000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] size_acc_r, size_acc_nxt;
  logic                 qempty_r, qempty_nxt;
  logic                 take;
  logic                 ok;
  logic                 ovf;
  logic [WIDE_W-1:0]    acc_wide;

  assign take     = !item_empty && (!item.is_end || !res_full);
  assign item_pop = take;
  assign res_push = take && item.is_end;

  // the top nibble must be clear before another digit fits
  assign ovf      = (size_acc_r[SIZE_BITS-1 -: 4] != 4'd0);
  assign acc_wide = WIDE_W'(size_acc_r);

  assign ok = (phase_r == PH_SIZE) || (phase_r == PH_NAME) || (phase_r == PH_TOKVAL) ||
              ((phase_r == PH_AFTERQ) && !qempty_r);

  assign res.chunk_size = ok ? acc_wide[OUT_SIZE_W-1:0] : '0;
  assign res.malformed  = !ok;

  always_comb begin
    phase_nxt    = phase_r;
    size_acc_nxt = size_acc_r;
    qempty_nxt   = qempty_r;
    if (take && item.is_end) begin
      phase_nxt    = PH_FIRST;
      size_acc_nxt = '0;
      qempty_nxt   = 1'b0;
    end else if (take) begin
      unique case (phase_r)
        PH_FIRST, PH_SIZE: begin
          if (item.is_hex) begin
            if (ovf) begin
              phase_nxt = PH_ERR;
            end else begin
              size_acc_nxt = {size_acc_r[SIZE_BITS-5:0], item.hex_val};
              phase_nxt    = PH_SIZE;
            end
          end else if (phase_r == PH_FIRST) begin
            phase_nxt = PH_ERR;
          end else if (item.is_ws) begin
            phase_nxt = PH_SIZE_WS;
          end else if (item.is_semi) begin
            phase_nxt = PH_SEMI_WS;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_SIZE_WS, PH_VAL_WS: begin
          if (!item.is_ws) begin
            phase_nxt = item.is_semi ? PH_SEMI_WS : PH_ERR;
          end
        end
        PH_SEMI_WS: begin
          if (!item.is_ws) begin
            phase_nxt = item.is_tchar ? PH_NAME : PH_ERR;
          end
        end
        PH_NAME, PH_NAME_WS: begin
          if ((phase_r == PH_NAME) && item.is_tchar) begin
            phase_nxt = PH_NAME;
          end else if (item.is_eq) begin
            phase_nxt = PH_EQ_WS;
          end else if (item.is_ws) begin
            phase_nxt = PH_NAME_WS;
          end else if (item.is_semi) begin
            phase_nxt = PH_SEMI_WS;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_EQ_WS: begin
          if (item.is_ws) begin
            phase_nxt = PH_EQ_WS;
          end else if (item.is_quote) begin
            phase_nxt  = PH_QSTR;
            qempty_nxt = 1'b1;
          end else begin
            phase_nxt = item.is_tchar ? PH_TOKVAL : PH_ERR;
          end
        end
        PH_TOKVAL: begin
          if (item.is_tchar) begin
            phase_nxt = PH_TOKVAL;
          end else if (item.is_ws) begin
            phase_nxt = PH_VAL_WS;
          end else if (item.is_semi) begin
            phase_nxt = PH_SEMI_WS;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_QSTR: begin
          if (item.is_quote) begin
            phase_nxt = PH_AFTERQ;
          end else begin
            qempty_nxt = 1'b0;
            if (item.is_bslash) begin
              phase_nxt = PH_QESC;
            end else if (item.is_ctl) begin
              phase_nxt = PH_ERR;
            end
          end
        end
        PH_QESC: begin
          phase_nxt = item.is_ctl ? PH_ERR : PH_QSTR;
        end
        PH_AFTERQ: begin
          qempty_nxt = 1'b0;
          if (item.is_ws) begin
            phase_nxt = PH_VAL_WS;
          end else if (item.is_semi) begin
            phase_nxt = PH_SEMI_WS;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        default: begin
          phase_nxt = PH_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      size_acc_r <= '0;
      qempty_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      size_acc_r <= size_acc_nxt;
      qempty_r   <= qempty_nxt;
    end
  end

endmodule

@@ hdl/chunk_size_line_parser_unit.sv @@
// ----------------------------------------------------------------------------
// chunk_size_line_parser_unit
// Parses one chunk-size line (hex size plus optional extensions) per end word.
// ----------------------------------------------------------------------------
// Feed the bytes of a chunk-size line, CRLF removed, one word per push, then
// one word with in_line_end set. The unit takes one word every clock as long
// as its input queue (QUEUE_DEPTH words) has room; the grammar walker in the
// back end retires one word per cycle while one is queued and only holds an
// end word while the result queue is full. The end word of a line passes
// the input queue and its result (size and malformed flag) the result queue
// before reaching the out_ ports, where it stays until popped. SIZE_BITS sets
// the width of the size accumulator; sizes above 2^SIZE_BITS-1 are reported
// as malformed, and out_chunk_size holds the low 31 bits of the size.
module chunk_size_line_parser_unit #(
  parameter int SIZE_BITS   = clp_pkg::SIZE_BITS_DEF,
  parameter int QUEUE_DEPTH = clp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                        [7:0] in_line_byte,
  input  logic                              in_line_end,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [clp_pkg::OUT_SIZE_W-1:0]    out_chunk_size,
  output logic                              out_malformed
);
  import clp_pkg::*;

  localparam int CLS_W = $bits(cls_t);
  localparam int RES_W = $bits(res_t);

  cls_t             cls_in;
  logic [CLS_W-1:0] cls_q;
  cls_t             item;
  logic             item_empty;
  logic             item_pop;
  res_t             res_in;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_q;
  res_t             res_out;

  clp_front u_front (
    .in_line_byte (in_line_byte),
    .in_line_end  (in_line_end),
    .cls          (cls_in)
  );

  clp_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CLS_W)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls_in),
    .full  (in_full),
    .pop   (item_pop),
    .dout  (cls_q),
    .empty (item_empty)
  );

  assign item = cls_t'(cls_q);

  clp_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  clp_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_q),
    .empty (out_empty)
  );

  assign res_out        = res_t'(res_q);
  assign out_chunk_size = res_out.chunk_size;
  assign out_malformed  = res_out.malformed;

`ifndef SYNTH
  // a rejected line never reports a size
  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_malformed) |-> (out_chunk_size == '0))
    else $error("malformed result carries a nonzero size");

  // every end word retired by the back end yields exactly one result
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (item_pop && item.is_end) |-> res_push)
    else $error("end word retired without a result");

  // the back end never writes into a full result queue
  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a word is only retired when one is waiting
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> !item_empty)
    else $error("back end retired a word from an empty queue");
`endif

endmodule
